@@ sv/rgb_led_interpolated_duty_unit_macros.svh @@
// ----------------------------------------------------------------------------
// RGB LED duty unit assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_INTERPOLATED_DUTY_UNIT_MACROS_SVH
`define RGB_LED_INTERPOLATED_DUTY_UNIT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define RGBDUTY_CHECK(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define RGBDUTY_IMPLY_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define RGBDUTY_IMPLY_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

@@ sv/rgbduty_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB LED duty unit package
// Request and result types, opcodes, status codes and the fixed arithmetic
// constants of the duty interpolation.
// ----------------------------------------------------------------------------
package rgbduty_pkg;

    // Field widths fixed by the request and result formats.
    localparam int COMP_W  = 8;
    localparam int DUTY_W  = 13;
    localparam int IDX_W   = 8;
    localparam int POS_W   = 24;
    localparam int REM_W   = 16;
    localparam int MUL_A_W = 29;
    localparam int MUL_B_W = 30;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Opcodes.
    localparam logic [2:0] OP_LOAD      = 3'd0;
    localparam logic [2:0] OP_CONFIG    = 3'd1;
    localparam logic [2:0] OP_SET_COLOR = 3'd2;
    localparam logic [2:0] OP_SET_LEVEL = 3'd3;
    localparam logic [2:0] OP_SET_BOTH  = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_CFG = 2'd1;
    localparam logic [1:0] ST_ALREADY = 2'd2;

    // Channel counter: red, green, blue.
    localparam logic [1:0] CHAN_LAST = 2'd2;

    // Full scale of color times brightness, 255 * 255.
    localparam logic [POS_W-1:0] FULL_SCALE = POS_W'(255 * 255);

    // Division by the full scale is a multiply by a rounded-up reciprocal.
    // With a 45-bit shift the quotient is exact for every dividend below 2**29.
    localparam int RECIP_SHIFT = 45;
    localparam logic [MUL_B_W-1:0] RECIP =
        MUL_B_W'((64'd1 << RECIP_SHIFT) / 64'd65025 + 64'd1);

    typedef struct packed {
        logic [2:0]        opcode;
        logic [1:0]        led;
        logic [4:0]        table_index;
        logic [DUTY_W-1:0] table_value;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] level;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [DUTY_W-1:0] duty_red;
        logic [DUTY_W-1:0] duty_green;
        logic [DUTY_W-1:0] duty_blue;
        logic [COMP_W-1:0] red_now;
        logic [COMP_W-1:0] green_now;
        logic [COMP_W-1:0] blue_now;
        logic [COMP_W-1:0] level_now;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic update;
        logic mul_lvl;
        logic mul_last;
        logic mul_recip;
        logic index;
        logic rd_end;
        logic frac;
        logic quot;
        logic duty;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic quiet;
        logic err;
        logic last_chan;
        logic out_busy;
    } t_sts;

endpackage

@@ sv/rgb_led_interpolated_duty_unit.sv @@
// A set or configure request runs the store update, three channel interpolations of eight
// steps each on one shared multiplier and one table read port, and the result write; on error
// it skips the interpolations. No new request is taken until its result is written. A load
// or an ignored opcode is taken every cycle while the block is idle and gives no result.
// Reset clears the controller, the result valid flag, the configured flags and the stored
// colors and levels; duty table entries stay undefined until they are loaded.
// ----------------------------------------------------------------------------
// RGB LED interpolated duty unit
// Keeps per-LED colors, brightness and duty tables and returns the three
// channel duties by linear interpolation in the LED's table.
// ----------------------------------------------------------------------------
module rgb_led_interpolated_duty_unit #(
    parameter int NUM_LEDS   = 4,
    parameter int LAST_ENTRY = 16,
    parameter int DUTY_BITS  = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rgbduty_pkg::t_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rgbduty_pkg::t_out  o_out_data
);

    rgbduty_pkg::t_cmd cmd;
    rgbduty_pkg::t_sts sts;

    // Request sequencing.
    rgbduty_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Stores, tables and arithmetic.
    rgbduty_dp #(
        .NUM_LEDS   (NUM_LEDS),
        .LAST_ENTRY (LAST_ENTRY),
        .DUTY_BITS  (DUTY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sv/rgbduty_ctrl.sv @@
// ----------------------------------------------------------------------------
// RGB LED duty unit controller
// Sequences one request at a time through the store update, three channel
// interpolations and the result write; a failed request skips the interpolations.
// ----------------------------------------------------------------------------
`include "rgb_led_interpolated_duty_unit_macros.svh"

module rgbduty_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rgbduty_pkg::t_sts  i_sts,
    output rgbduty_pkg::t_cmd  o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_UPDATE    = 11'b000_0000_0010,
        S_MUL_LVL   = 11'b000_0000_0100,
        S_MUL_LAST  = 11'b000_0000_1000,
        S_MUL_RECIP = 11'b000_0001_0000,
        S_INDEX     = 11'b000_0010_0000,
        S_RD_END    = 11'b000_0100_0000,
        S_FRAC      = 11'b000_1000_0000,
        S_QUOT      = 11'b001_0000_0000,
        S_DUTY      = 11'b010_0000_0000,
        S_EMIT      = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && !i_sts.quiet) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = i_sts.err ? S_EMIT : S_MUL_LVL;
            end
            S_MUL_LVL: begin
                o_cmd.mul_lvl = 1'b1;
                n_state = S_MUL_LAST;
            end
            S_MUL_LAST: begin
                o_cmd.mul_last = 1'b1;
                n_state = S_MUL_RECIP;
            end
            S_MUL_RECIP: begin
                o_cmd.mul_recip = 1'b1;
                n_state = S_INDEX;
            end
            S_INDEX: begin
                o_cmd.index = 1'b1;
                n_state = S_RD_END;
            end
            S_RD_END: begin
                o_cmd.rd_end = 1'b1;
                n_state = S_FRAC;
            end
            S_FRAC: begin
                o_cmd.frac = 1'b1;
                n_state = S_QUOT;
            end
            S_QUOT: begin
                o_cmd.quot = 1'b1;
                n_state = S_DUTY;
            end
            S_DUTY: begin
                o_cmd.duty = 1'b1;
                n_state = i_sts.last_chan ? S_EMIT : S_MUL_LVL;
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `RGBDUTY_IMPLY_NEXT(a_accept_starts, i_in_valid && o_in_ready && !i_sts.quiet, r_state == S_UPDATE, "accepted request did not start its update")
    `RGBDUTY_IMPLY_NEXT(a_err_skips, r_state == S_UPDATE && i_sts.err, r_state == S_EMIT, "failed request did not go straight to its result")
    `RGBDUTY_IMPLY_NEXT(a_last_emits, r_state == S_DUTY && i_sts.last_chan, r_state == S_EMIT, "blue channel done but no result write followed")

endmodule

@@ sv/rgbduty_dp.sv @@
// ----------------------------------------------------------------------------
// RGB LED duty unit datapath
// Holds the per-LED stores and duty tables, the shared multiplier, the
// interpolation registers and the result register.
// ----------------------------------------------------------------------------
`include "rgb_led_interpolated_duty_unit_macros.svh"

module rgbduty_dp #(
    parameter int NUM_LEDS   = 4,
    parameter int LAST_ENTRY = 16,
    parameter int DUTY_BITS  = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rgbduty_pkg::t_in   i_in_data,
    input  rgbduty_pkg::t_cmd  i_cmd,
    output rgbduty_pkg::t_sts  o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output rgbduty_pkg::t_out  o_out_data
);

    localparam int ENTRIES   = LAST_ENTRY + 1;
    localparam int MEM_DEPTH = NUM_LEDS * ENTRIES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int COMP_W    = rgbduty_pkg::COMP_W;
    localparam int DUTY_W    = rgbduty_pkg::DUTY_W;
    localparam int IDX_W     = rgbduty_pkg::IDX_W;
    localparam int POS_W     = rgbduty_pkg::POS_W;
    localparam int REM_W     = rgbduty_pkg::REM_W;
    localparam int PROD_W    = rgbduty_pkg::PROD_W;
    localparam int SHIFT     = rgbduty_pkg::RECIP_SHIFT;

    // Duty reference tables of all LEDs, one row of entries per LED.
    logic [DUTY_BITS-1:0] mem [MEM_DEPTH];
    logic [DUTY_BITS-1:0] r_rd;

    // Per-LED stores.
    logic [NUM_LEDS-1:0]       r_flag;
    logic [3*COMP_W-1:0]       r_color [NUM_LEDS];
    logic [COMP_W-1:0]         r_level [NUM_LEDS];

    // Accepted request.
    rgbduty_pkg::t_in          r_item;
    logic                      r_led_ok;

    // Interpolation registers.
    logic [1:0]                r_status;
    logic [1:0]                r_chan;
    logic [PROD_W-1:0]         r_prod;
    logic [POS_W-1:0]          r_pos;
    logic [REM_W-1:0]          r_rem;
    logic [IDX_W-1:0]          r_j;
    logic [DUTY_W-1:0]         r_start;
    logic                      r_neg;
    logic [DUTY_W-1:0]         r_duty [3];

    // Result register.
    rgbduty_pkg::t_out         r_out;
    logic                      r_out_valid;

    logic                      in_led_ok;
    logic [LED_W-1:0]          in_slot;
    logic                      tbl_wr;
    logic [ADDR_W-1:0]         wr_addr;
    logic [LED_W-1:0]          slot;
    logic                      cur_flag;
    logic [3*COMP_W-1:0]       cur_color;
    logic [COMP_W-1:0]         cur_level;
    logic [1:0]                n_status;
    logic [COMP_W-1:0]         comp;
    logic [rgbduty_pkg::MUL_A_W-1:0] mul_a;
    logic [rgbduty_pkg::MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]         n_prod;
    logic [IDX_W-1:0]          raw_i;
    logic                      at_end;
    logic [IDX_W-1:0]          idx_i;
    logic [IDX_W-1:0]          idx_j;
    logic [REM_W-1:0]          n_rem;
    logic [ADDR_W-1:0]         rd_addr;
    logic [DUTY_W-1:0]         rd_val;
    logic signed [DUTY_W:0]    diff;
    logic [DUTY_W-1:0]         abs_diff;
    logic [DUTY_W-1:0]         quot;
    logic [DUTY_W-1:0]         n_duty;

    // Incoming request decode: slot range and table write.
    always_comb begin
        in_led_ok = 32'(i_in_data.led) < NUM_LEDS;
        in_slot   = LED_W'(i_in_data.led);
        tbl_wr    = i_cmd.load && (i_in_data.opcode == rgbduty_pkg::OP_LOAD) && in_led_ok
                    && (32'(i_in_data.table_index) <= LAST_ENTRY);
        wr_addr   = ADDR_W'(32'(in_slot) * ENTRIES + 32'(i_in_data.table_index));
    end

    // Stored values of the addressed slot; a slot out of range reads as zero.
    always_comb begin
        slot      = LED_W'(r_item.led);
        cur_flag  = r_led_ok && r_flag[slot];
        cur_color = r_led_ok ? r_color[slot] : '0;
        cur_level = r_led_ok ? r_level[slot] : '0;
    end

    // Status of the request, before its store update, and the controller status.
    always_comb begin
        if (!r_led_ok) begin
            n_status = rgbduty_pkg::ST_NOT_CFG;
        end else if (r_item.opcode == rgbduty_pkg::OP_CONFIG) begin
            n_status = cur_flag ? rgbduty_pkg::ST_ALREADY : rgbduty_pkg::ST_OK;
        end else begin
            n_status = cur_flag ? rgbduty_pkg::ST_OK : rgbduty_pkg::ST_NOT_CFG;
        end
        // Loads, spare opcodes and configures of a missing slot give no result.
        o_sts.quiet     = (i_in_data.opcode == rgbduty_pkg::OP_LOAD)
                          || (i_in_data.opcode > rgbduty_pkg::OP_SET_BOTH)
                          || ((i_in_data.opcode == rgbduty_pkg::OP_CONFIG) && !in_led_ok);
        o_sts.err       = n_status != rgbduty_pkg::ST_OK;
        o_sts.last_chan = r_chan == rgbduty_pkg::CHAN_LAST;
        o_sts.out_busy  = r_out_valid && !i_out_ready;
    end

    // Table write port.
    always_ff @(posedge i_clk) begin
        if (tbl_wr) begin
            mem[wr_addr] <= i_in_data.table_value[DUTY_BITS-1:0];
        end
    end

    // Table read port: lower entry during the index step, upper entry after.
    always_comb begin
        rd_addr = ADDR_W'(32'(slot) * ENTRIES + 32'(i_cmd.index ? idx_i : r_j));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.index || i_cmd.rd_end) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Per-LED stores, updated once per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= '0;
            for (int k = 0; k < NUM_LEDS; k++) begin
                r_color[k] <= '0;
                r_level[k] <= '0;
            end
        end else if (i_cmd.update && r_led_ok) begin
            if (r_item.opcode == rgbduty_pkg::OP_CONFIG) begin
                if (!cur_flag) begin
                    r_flag[slot]  <= 1'b1;
                    r_color[slot] <= {r_item.red, r_item.green, r_item.blue};
                    r_level[slot] <= r_item.level;
                end
            end else if (cur_flag) begin
                if (r_item.opcode == rgbduty_pkg::OP_SET_COLOR
                    || r_item.opcode == rgbduty_pkg::OP_SET_BOTH) begin
                    r_color[slot] <= {r_item.red, r_item.green, r_item.blue};
                end
                if (r_item.opcode == rgbduty_pkg::OP_SET_LEVEL
                    || r_item.opcode == rgbduty_pkg::OP_SET_BOTH) begin
                    r_level[slot] <= r_item.level;
                end
            end
        end
    end

    // Component of the channel in progress.
    always_comb begin
        unique case (r_chan)
            2'd0:    comp = cur_color[3*COMP_W-1:2*COMP_W];
            2'd1:    comp = cur_color[2*COMP_W-1:COMP_W];
            default: comp = cur_color[COMP_W-1:0];
        endcase
    end

    // Difference of the two table entries, split into sign and magnitude.
    always_comb begin
        rd_val   = DUTY_W'(r_rd);
        diff     = $signed({1'b0, rd_val}) - $signed({1'b0, r_start});
        abs_diff = diff[DUTY_W] ? DUTY_W'(-diff) : DUTY_W'(diff);
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        priority if (i_cmd.mul_lvl) begin
            mul_a = rgbduty_pkg::MUL_A_W'(comp);
            mul_b = rgbduty_pkg::MUL_B_W'(cur_level);
        end else if (i_cmd.mul_last) begin
            mul_a = rgbduty_pkg::MUL_A_W'(r_prod[2*COMP_W-1:0]);
            mul_b = rgbduty_pkg::MUL_B_W'(LAST_ENTRY);
        end else if (i_cmd.mul_recip) begin
            mul_a = rgbduty_pkg::MUL_A_W'(r_prod[POS_W-1:0]);
            mul_b = rgbduty_pkg::RECIP;
        end else if (i_cmd.frac) begin
            mul_a = rgbduty_pkg::MUL_A_W'(abs_diff);
            mul_b = rgbduty_pkg::MUL_B_W'(r_rem);
        end else if (i_cmd.quot) begin
            mul_a = r_prod[rgbduty_pkg::MUL_A_W-1:0];
            mul_b = rgbduty_pkg::RECIP;
        end else begin
            mul_a = '0;
            mul_b = '0;
        end
        n_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Table index, clamped upper index and remainder of the position.
    always_comb begin
        raw_i  = r_prod[SHIFT +: IDX_W];
        at_end = raw_i >= IDX_W'(LAST_ENTRY);
        idx_i  = at_end ? IDX_W'(LAST_ENTRY) : raw_i;
        idx_j  = at_end ? IDX_W'(LAST_ENTRY) : IDX_W'(raw_i + 1'b1);
        n_rem  = REM_W'(r_pos - POS_W'(raw_i) * rgbduty_pkg::FULL_SCALE);
    end

    // Interpolated duty: lower entry plus the signed, truncated fraction.
    always_comb begin
        quot   = r_prod[SHIFT +: DUTY_W];
        n_duty = r_neg ? DUTY_W'(r_start - quot) : DUTY_W'(r_start + quot);
    end

    // Request capture and interpolation registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item   <= i_in_data;
            r_led_ok <= in_led_ok;
        end
        if (i_cmd.mul_lvl || i_cmd.mul_last || i_cmd.mul_recip || i_cmd.frac
            || i_cmd.quot) begin
            r_prod <= n_prod;
        end
        if (i_cmd.mul_recip) begin
            r_pos <= r_prod[POS_W-1:0];
        end
        if (i_cmd.index) begin
            r_rem <= n_rem;
            r_j   <= idx_j;
        end
        if (i_cmd.rd_end) begin
            r_start <= rd_val;
        end
        if (i_cmd.frac) begin
            r_neg <= diff[DUTY_W];
        end
        if (i_cmd.update) begin
            r_status <= n_status;
            r_chan   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_duty[k] <= '0;
            end
        end else if (i_cmd.duty) begin
            r_duty[r_chan] <= n_duty;
            r_chan         <= r_chan + 2'd1;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.status     <= r_status;
            r_out.duty_red   <= r_duty[0];
            r_out.duty_green <= r_duty[1];
            r_out.duty_blue  <= r_duty[2];
            r_out.red_now    <= cur_color[3*COMP_W-1:2*COMP_W];
            r_out.green_now  <= cur_color[2*COMP_W-1:COMP_W];
            r_out.blue_now   <= cur_color[COMP_W-1:0];
            r_out.level_now  <= cur_level;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RGBDUTY_IMPLY_NOW(a_err_zero_duty, r_out_valid && r_out.status != rgbduty_pkg::ST_OK, r_out.duty_red == '0 && r_out.duty_green == '0 && r_out.duty_blue == '0, "failed request carries a nonzero duty")
    `RGBDUTY_IMPLY_NOW(a_index_range, i_cmd.index, raw_i <= IDX_W'(LAST_ENTRY), "table index beyond the last entry")
    `RGBDUTY_CHECK(a_chan_range, r_chan <= rgbduty_pkg::CHAN_LAST || !(i_cmd.duty || i_cmd.mul_lvl), "channel counter past blue")

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED interpolated duty unit testbench
// Loads duty tables, configures LEDs and updates their colors and levels while
// a scoreboard class predicts every result, including the interpolated duties,
// and checks it field by field. Bursty requests, a patterned result stall and
// one long hold-off of the result side exercise the handshakes.
// ----------------------------------------------------------------------------
module testbench;
    import rgbduty_pkg::*;

    localparam int LEDS            = 4;
    localparam int LAST            = 16;
    localparam int FULL            = 255 * 255;
    localparam int TOTAL_REQUESTS  = 850;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 40;

    // Opcodes the block ignores.
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Result side stall patterns.
    typedef enum int {RX_STEADY, RX_ALTERNATE, RX_RANDOM, RX_SPARSE} rx_mode_e;

    // Predicts the result of every accepted request and checks what the block returns.
    class duty_scoreboard;
        bit [DUTY_W-1:0] duty_tbl [LEDS][LAST+1];
        bit              loaded   [LEDS][LAST+1];
        bit [COMP_W-1:0] red_st   [LEDS];
        bit [COMP_W-1:0] green_st [LEDS];
        bit [COMP_W-1:0] blue_st  [LEDS];
        bit [COMP_W-1:0] level_st [LEDS];
        bit              configured [LEDS];
        t_out            expected_q [$];
        int              errors;

        // Lowest table entry of an LED not yet loaded, LAST + 1 when all are.
        function int first_unloaded(int led);
            for (int k = 0; k <= LAST; k++) begin
                if (!loaded[led][k]) return k;
            end
            return LAST + 1;
        endfunction

        // Linear interpolation between the two table entries around the position.
        function bit [DUTY_W-1:0] interp_duty(int led, bit [COMP_W-1:0] comp,
                                              bit [COMP_W-1:0] lvl);
            int pos;
            int lo;
            int hi;
            int rem;
            int d;
            pos = int'(comp) * int'(lvl) * LAST;
            lo  = pos / FULL;
            if (lo >= LAST) begin
                lo = LAST;
                hi = LAST;
            end else begin
                hi = lo + 1;
            end
            rem = pos % FULL;
            d = int'(duty_tbl[led][lo]) +
                ((int'(duty_tbl[led][hi]) - int'(duty_tbl[led][lo])) * rem) / FULL;
            return d[DUTY_W-1:0];
        endfunction

        function void note_request(t_in req);
            t_out res;
            int   led;
            led = req.led;
            // Table loads update state only; out of range indexes are dropped.
            if (req.opcode == OP_LOAD) begin
                if (req.table_index <= LAST) begin
                    duty_tbl[led][req.table_index] = req.table_value;
                    loaded[led][req.table_index]   = 1'b1;
                end
                return;
            end
            if (req.opcode > OP_SET_BOTH) return;

            res = '0;
            res.status = ST_OK;
            if (req.opcode == OP_CONFIG) begin
                if (configured[led]) begin
                    res.status = ST_ALREADY;
                end else begin
                    configured[led] = 1'b1;
                    red_st[led]     = req.red;
                    green_st[led]   = req.green;
                    blue_st[led]    = req.blue;
                    level_st[led]   = req.level;
                end
            end else if (!configured[led]) begin
                res.status = ST_NOT_CFG;
            end else begin
                if (req.opcode == OP_SET_COLOR || req.opcode == OP_SET_BOTH) begin
                    red_st[led]   = req.red;
                    green_st[led] = req.green;
                    blue_st[led]  = req.blue;
                end
                if (req.opcode == OP_SET_LEVEL || req.opcode == OP_SET_BOTH) begin
                    level_st[led] = req.level;
                end
            end

            // Duties only on success; stored values are reported either way.
            if (res.status == ST_OK) begin
                res.duty_red   = interp_duty(led, red_st[led], level_st[led]);
                res.duty_green = interp_duty(led, green_st[led], level_st[led]);
                res.duty_blue  = interp_duty(led, blue_st[led], level_st[led]);
            end
            res.red_now   = red_st[led];
            res.green_now = green_st[led];
            res.blue_now  = blue_st[led];
            res.level_now = level_st[led];
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [DUTY_W-1:0] want,
                                    logic [DUTY_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status",     want.status,     got.status);
            compare_field("duty_red",   want.duty_red,   got.duty_red);
            compare_field("duty_green", want.duty_green, got.duty_green);
            compare_field("duty_blue",  want.duty_blue,  got.duty_blue);
            compare_field("red_now",    want.red_now,    got.red_now);
            compare_field("green_now",  want.green_now,  got.green_now);
            compare_field("blue_now",   want.blue_now,   got.blue_now);
            compare_field("level_now",  want.level_now,  got.level_now);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    duty_scoreboard sb = new();
    int n_accepted = 0;

    rgb_led_interpolated_duty_unit #(
        .NUM_LEDS   (LEDS),
        .LAST_ENTRY (LAST),
        .DUTY_BITS  (DUTY_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // Offer one request and hold it until the block takes it.
    task automatic send_request(t_in req);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_request(req);
        n_accepted++;
    endtask

    task automatic pause_sender(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic t_in build(logic [2:0] op, int led, int idx, int val,
                                  int r, int g, int b, int lv);
        t_in req;
        req.opcode      = op;
        req.led         = 2'(led);
        req.table_index = 5'(idx);
        req.table_value = DUTY_W'(val);
        req.red         = COMP_W'(r);
        req.green       = COMP_W'(g);
        req.blue        = COMP_W'(b);
        req.level       = COMP_W'(lv);
        return req;
    endfunction

    // Color and level values lean toward the extremes.
    function automatic int byte_value();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Request side: reset, directed requests, then random bursts.
    initial begin
        t_in req;
        int  burst;
        int  pick;
        int  led;
        int  gap_idx;
        int  n_effective;
        bit  reads_table;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Set on an LED that was never configured.
        send_request(build(OP_SET_COLOR, 1, 0, 0, 255, 255, 255, 255));
        // Spare opcodes are ignored.
        for (int s = OP_SPARE_LO; s <= OP_SPARE_HI; s++) begin
            send_request(build(3'(s), 0, 3, 8191, 255, 255, 255, 255));
        end
        // Loads beyond the last entry are dropped.
        send_request(build(OP_LOAD, 0, 31, 8191, 0, 0, 0, 0));
        send_request(build(OP_LOAD, 0, LAST + 1, 4096, 0, 0, 0, 0));
        // Full table for LED 0 with a falling segment and both value extremes.
        for (int k = 0; k <= LAST; k++) begin
            case (k)
                0:        pick = 0;
                1:        pick = 4096;
                2:        pick = 0;
                LAST - 1: pick = 4096;
                LAST:     pick = 8191;
                default:  pick = $urandom_range(0, 4096);
            endcase
            send_request(build(OP_LOAD, 0, k, pick, 0, 0, 0, 0));
        end
        send_request(build(OP_CONFIG, 0, 0, 0, 255, 0, 128, 255));
        // A second configure is refused and leaves the values alone.
        send_request(build(OP_CONFIG, 0, 0, 0, 0, 0, 0, 0));
        send_request(build(OP_SET_COLOR, 0, 0, 0, 0, 255, 1, 0));
        send_request(build(OP_SET_LEVEL, 0, 0, 0, 0, 0, 0, 0));
        pause_sender(3);
        send_request(build(OP_SET_BOTH, 0, 0, 0, 128, 64, 255, 128));
        send_request(build(OP_SET_BOTH, 3, 0, 0, 10, 20, 30, 40));
        pause_sender(2);

        // Random bursts; requests the block ignores do not count.
        n_effective = 0;
        while (n_effective < TOTAL_REQUESTS) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
            for (int n = 0; n < burst && n_effective < TOTAL_REQUESTS; n++) begin
                led = $urandom_range(0, LEDS - 1);
                req = build(OP_LOAD, led, $urandom_range(0, 31), $urandom_range(0, 8191),
                            byte_value(), byte_value(), byte_value(), byte_value());
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    req.opcode      = OP_LOAD;
                    req.table_index = ($urandom_range(0, 9) == 0) ?
                                      5'($urandom_range(LAST + 1, 31)) :
                                      5'($urandom_range(0, LAST));
                    if ($urandom_range(0, 3) != 0) begin
                        req.table_value = DUTY_W'($urandom_range(0, 4096));
                    end
                end else if (pick < 38) begin
                    req.opcode = OP_CONFIG;
                end else if (pick < 58) begin
                    req.opcode = OP_SET_COLOR;
                end else if (pick < 72) begin
                    req.opcode = OP_SET_LEVEL;
                end else if (pick < 95) begin
                    req.opcode = OP_SET_BOTH;
                end else begin
                    req.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                end

                // A successful update reads the table, so it must be fully loaded
                // first; otherwise load the missing entry instead.
                reads_table = 1'b0;
                if (req.opcode == OP_CONFIG) begin
                    reads_table = !sb.configured[led];
                end else if (req.opcode != OP_LOAD && req.opcode <= OP_SET_BOTH) begin
                    reads_table = sb.configured[led];
                end
                gap_idx = sb.first_unloaded(led);
                if (reads_table && gap_idx <= LAST) begin
                    req.opcode      = OP_LOAD;
                    req.table_index = 5'(gap_idx);
                end

                send_request(req);
                if (req.opcode <= OP_SET_BOTH &&
                    !(req.opcode == OP_LOAD && req.table_index > LAST)) begin
                    n_effective++;
                end
            end
            pause_sender($urandom_range(1, 8));
        end

        // Drain, then allow time for any stray result.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: changing stall patterns plus one long hold-off mid-run.
    initial begin
        rx_mode_e mode;
        int       span;
        bit       hold_done;
        i_out_ready <= 1'b0;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!hold_done && n_accepted >= HOLD_OFF_AFTER) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            mode = rx_mode_e'($urandom_range(0, 3));
            span = $urandom_range(10, 60);
            for (int phase = 0; phase < span; phase++) begin
                case (mode)
                    RX_STEADY:    i_out_ready <= 1'b1;
                    RX_ALTERNATE: i_out_ready <= phase[0];
                    RX_RANDOM:    i_out_ready <= ($urandom_range(0, 3) != 0);
                    default:      i_out_ready <= (phase % 4 == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Check every result the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            sb.check_result(o_out_data);
        end
    end

    // End the run if neither side moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule
